>>> rtl/core/clid_pkg.sv
// ----------------------------------------------------------------------------
// Chopper lock-in demodulator package
// Shared widths, register codes, controller/datapath command and status
// structs, and the octant sine/cosine series used to build the phase table.
// ----------------------------------------------------------------------------
`default_nettype none

package clid_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 65536;
  localparam int unsigned MAX_PERIOD_DEF   = 1024;
  localparam int unsigned PHASE_BITS_DEF   = 10;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned WLEN_W    = 17;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned MAG_W     = 16;
  localparam int unsigned CIDX_W    = 16;
  localparam int unsigned COEF_W    = 17;
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned MEAN_W    = 31;
  localparam int unsigned CS_W      = 2 * COEF_W;

  localparam logic [WLEN_W-1:0]    WLEN_RESET = 17'd65536;
  localparam logic [MAG_W:0]       MAG_MAX    = 17'd32768;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_LR  = 1'b1;

  localparam logic [63:0] Q30_ONE       = 64'd1073741824;
  localparam logic [63:0] PI_OVER_4_Q30 = 64'd843314857;

  typedef struct packed {
    logic load;
    logic decide;
    logic issue;
    logic latch_phase;
    logic tab;
    logic cs;
    logic mul;
    logic rd_oldest;
    logic drop;
    logic push;
    logic chunk;
    logic mean_re;
    logic mean_im;
    logic mean_fin;
    logic sq1;
    logic sq2;
    logic sqrt_start;
    logic emit;
  } clid_cmd_t;

  typedef struct packed {
    logic ref_edge;
    logic div_done;
    logic last;
    logic fill_ge_len;
    logic fill_gt_len;
    logic fill_eq_len;
    logic end_flag;
    logic mean_done;
    logic sqrt_done;
    logic out_busy;
  } clid_stat_t;

  // r: angle with 2^32 per turn, in [0, 2^29] (one octant) -> {sin, cos} rounded to Q1.15
  function automatic logic [CS_W-1:0] clid_taylor(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] sn;
    logic [63:0] cs;
    logic [63:0] s15;
    logic [63:0] c15;
    x  = (r * PI_OVER_4_Q30) >> 29;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    sn = (x * t) >> 30;
    t  = Q30_ONE - x2 / 64'd90;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd56;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd30;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd12;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd2;
    cs = t;
    s15 = (sn + 64'd16384) >> 15;
    c15 = (cs + 64'd16384) >> 15;
    return {s15[COEF_W-1:0], c15[COEF_W-1:0]};
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/clid_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// One quotient bit per cycle; the remainder may be preloaded.
// ----------------------------------------------------------------------------
`default_nettype none

module clid_div #(
  parameter int unsigned NW = 11,
  parameter int unsigned DW = 11
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] rem_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic [NW-1:0]      quot_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [DW-1:0] rem_q;
  logic [NW-1:0] sh_q;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_q, sh_q[NW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      sh_q  <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
      sh_q  <= {sh_q[NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

`default_nettype wire

>>> rtl/core/clid_sqrt.sv
// ----------------------------------------------------------------------------
// Integer square root
// Floor root of a VW-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module clid_sqrt #(
  parameter int unsigned VW = 62
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [VW-1:0]   val_i,
  output logic                 done_o,
  output logic [VW/2-1:0]      root_o
);

  localparam int unsigned RW = VW / 2;
  localparam int unsigned CW = $clog2(RW + 1);

  logic [VW-1:0] v_q;
  logic [VW-1:0] res_q;
  logic [VW-1:0] bit_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [VW-1:0] trial;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(RW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      res_q <= '0;
      bit_q <= VW'(1) << (VW - 2);
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[RW-1:0];

endmodule

`default_nettype wire

>>> rtl/core/clid_datapath.sv
// ----------------------------------------------------------------------------
// Lock-in datapath
// Edge detect, period buffer, phase divider and table, complex products,
// sliding window with running sums, mean and magnitude, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module clid_datapath #(
  parameter int unsigned WINDOW_DEPTH = clid_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned MAX_PERIOD   = clid_pkg::MAX_PERIOD_DEF,
  parameter int unsigned PHASE_BITS   = clid_pkg::PHASE_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire clid_pkg::clid_cmd_t                 cmd_i,
  output clid_pkg::clid_stat_t                     stat_o,
  input  wire logic                                cfg_valid_i,
  input  wire logic [clid_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [clid_pkg::WLEN_W-1:0]         cfg_data_i,
  input  wire logic signed [clid_pkg::SAMPLE_W-1:0] in_signal_i,
  input  wire logic signed [clid_pkg::SAMPLE_W-1:0] in_reference_i,
  input  wire logic                                in_end_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [clid_pkg::MAG_W-1:0]               out_magnitude_o,
  output logic [clid_pkg::CIDX_W-1:0]              out_chunk_index_o
);

  localparam int unsigned SW     = clid_pkg::SAMPLE_W;
  localparam int unsigned HW     = $clog2(WINDOW_DEPTH);
  localparam int unsigned LEN_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned EW     = (LEN_W > clid_pkg::WLEN_W) ? LEN_W : clid_pkg::WLEN_W;
  localparam int unsigned SUM_W  = HW + 32;
  localparam int unsigned PI_W   = $clog2(MAX_PERIOD);
  localparam int unsigned PC_W   = $clog2(MAX_PERIOD + 1);
  localparam int unsigned QW     = PHASE_BITS + 1;
  localparam int unsigned PN_W   = PI_W + PHASE_BITS + 1;
  localparam int unsigned TI_W   = PHASE_BITS - 2;
  localparam int unsigned TAB_N  = 2 ** (PHASE_BITS - 3) + 1;
  localparam int unsigned CW     = clid_pkg::COEF_W;
  localparam int unsigned PW     = clid_pkg::PROD_W;
  localparam int unsigned MW     = clid_pkg::MEAN_W;
  localparam int unsigned SQ_W   = 2 * MW;

  typedef logic [clid_pkg::CS_W-1:0] cs_tab_t [TAB_N];

  function automatic cs_tab_t build_tab();
    cs_tab_t tab;
    for (int k = 0; k < TAB_N; k++) begin
      tab[k] = clid_pkg::clid_taylor(64'(k) << (32 - PHASE_BITS));
    end
    return tab;
  endfunction

  localparam cs_tab_t CS_TAB = build_tab();

  // configuration
  logic [clid_pkg::WLEN_W-1:0] wlen_q;
  logic                        inv_q;

  // input word
  logic signed [SW-1:0] sig_q;
  logic signed [SW-1:0] ref_q;
  logic                 end_q;

  // period tracking
  logic signed [SW-1:0] prev_ref_q;
  logic                 prev_valid_q;
  logic                 armed_q;
  logic [PC_W-1:0]      pc_q;
  logic signed [SW-1:0] pmem [MAX_PERIOD];
  logic signed [SW-1:0] prd_q;
  logic [PI_W-1:0]      n_q;
  logic [PI_W-1:0]      j_q;
  logic [PC_W-1:0]      p_q;

  // product path
  logic signed [SW-1:0]         samp_q;
  logic [PHASE_BITS-1:0]        phase_q;
  logic [clid_pkg::CS_W-1:0]    tab_q;
  logic                         lo_q;
  logic [1:0]                   quad_q;
  logic signed [CW-1:0]         cos_q;
  logic signed [CW-1:0]         sin_q;
  logic signed [PW-1:0]         re_q;
  logic signed [PW-1:0]         im_q;

  // window
  logic [2*PW-1:0]       wmem [WINDOW_DEPTH];
  logic [2*PW-1:0]       wrd_q;
  logic [HW-1:0]         head_q;
  logic [LEN_W-1:0]      fill_q;
  logic signed [SUM_W-1:0] sum_re_q;
  logic signed [SUM_W-1:0] sum_im_q;

  // result
  logic [clid_pkg::CIDX_W-1:0] cnt_q;
  logic [MW-1:0]               mr_q;
  logic [MW-1:0]               mi_q;
  logic [SQ_W-1:0]             sq_q;
  logic [SQ_W-1:0]             acc_q;
  logic                        out_valid_q;
  logic [clid_pkg::MAG_W-1:0]  mag_q;
  logic [clid_pkg::CIDX_W-1:0] cidx_q;

  // combinational
  logic                  ref_edge;
  logic                  restart;
  logic                  pwe;
  logic [EW-1:0]         wl_ext;
  logic [LEN_W-1:0]      eff_len;
  logic [LEN_W:0]        odiff;
  logic [LEN_W:0]        owrap;
  logic [HW-1:0]         old_idx;
  logic [PN_W-1:0]       pnum;
  logic                  pdiv_done;
  logic [QW-1:0]         pquot;
  logic [TI_W-1:0]       tk;
  logic                  tlo;
  logic [TI_W-1:0]       tidx;
  logic [CW-1:0]         s0;
  logic [CW-1:0]         c0;
  logic signed [CW-1:0]  s0s;
  logic signed [CW-1:0]  c0s;
  logic signed [SW+CW-1:0] pre;
  logic signed [SW+CW-1:0] pim;
  logic signed [SUM_W-1:0] sum_sel;
  logic [SUM_W-1:0]      sum_abs;
  logic [SUM_W-1:0]      mnum;
  logic                  mdiv_done;
  logic [SUM_W-1:0]      mquot;
  logic                  sqrt_done;
  logic [MW-1:0]         root;
  logic [MW:0]           rnd;
  logic [clid_pkg::MAG_W:0] mag_full;

  assign ref_edge = prev_valid_q && prev_ref_q[SW-1] && !ref_q[SW-1];
  assign restart  = !armed_q || (pc_q >= PC_W'(MAX_PERIOD));
  assign pwe      = cmd_i.decide && !ref_edge && armed_q && (pc_q < PC_W'(MAX_PERIOD));

  assign wl_ext  = EW'(wlen_q);
  assign eff_len = (wlen_q == '0) ? LEN_W'(1) :
                   (wl_ext > EW'(WINDOW_DEPTH)) ? LEN_W'(WINDOW_DEPTH) : LEN_W'(wl_ext);

  assign odiff   = (LEN_W+1)'(head_q) - (LEN_W+1)'(fill_q);
  assign owrap   = odiff[LEN_W] ? odiff + (LEN_W+1)'(WINDOW_DEPTH) : odiff;
  assign old_idx = HW'(owrap);

  assign pnum = (PN_W'(j_q) << PHASE_BITS) + PN_W'(p_q >> 1);

  clid_div #(
    .NW (QW),
    .DW (PC_W)
  ) u_phase_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.issue),
    .rem_i   (PC_W'(pnum >> QW)),
    .num_i   (pnum[QW-1:0]),
    .den_i   (p_q),
    .done_o  (pdiv_done),
    .quot_o  (pquot)
  );

  assign tk   = phase_q[TI_W-1:0];
  assign tlo  = tk <= TI_W'(TAB_N - 1);
  assign tidx = tlo ? tk : TI_W'(0) - tk;

  assign s0  = lo_q ? tab_q[2*CW-1:CW] : tab_q[CW-1:0];
  assign c0  = lo_q ? tab_q[CW-1:0] : tab_q[2*CW-1:CW];
  assign s0s = signed'(s0);
  assign c0s = signed'(c0);

  assign pre = samp_q * cos_q;
  assign pim = samp_q * sin_q;

  assign sum_sel = cmd_i.mean_re ? sum_re_q : sum_im_q;
  assign sum_abs = sum_sel[SUM_W-1] ? unsigned'(-sum_sel) : unsigned'(sum_sel);
  assign mnum    = sum_abs + SUM_W'(eff_len >> 1);

  clid_div #(
    .NW (SUM_W),
    .DW (LEN_W)
  ) u_mean_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mean_re | cmd_i.mean_im),
    .rem_i   ('0),
    .num_i   (mnum),
    .den_i   (eff_len),
    .done_o  (mdiv_done),
    .quot_o  (mquot)
  );

  clid_sqrt #(
    .VW (SQ_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .val_i   (acc_q + sq_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign rnd      = (MW+1)'(root) + (MW+1)'(16384);
  assign mag_full = rnd[MW:15];

  // configuration and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q       <= clid_pkg::WLEN_RESET;
      inv_q        <= 1'b0;
      prev_ref_q   <= '0;
      prev_valid_q <= 1'b0;
      armed_q      <= 1'b0;
      pc_q         <= '0;
      head_q       <= '0;
      fill_q       <= '0;
      sum_re_q     <= '0;
      sum_im_q     <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == clid_pkg::CFG_WINDOW_LEN) begin
          wlen_q <= cfg_data_i;
        end else if (cfg_index_i == clid_pkg::CFG_INVERT_LR) begin
          inv_q <= cfg_data_i[0];
        end
      end
      if (cmd_i.decide) begin
        prev_ref_q   <= ref_q;
        prev_valid_q <= 1'b1;
        if (ref_edge) begin
          armed_q <= 1'b1;
          pc_q    <= '0;
        end else if (armed_q) begin
          if (pc_q < PC_W'(MAX_PERIOD)) begin
            pc_q <= pc_q + 1'b1;
          end else begin
            armed_q <= 1'b0;
            pc_q    <= '0;
          end
        end
      end
      if (cmd_i.drop) begin
        sum_re_q <= sum_re_q - SUM_W'(signed'(wrd_q[PW-1:0]));
        sum_im_q <= sum_im_q - SUM_W'(signed'(wrd_q[2*PW-1:PW]));
        fill_q   <= fill_q - 1'b1;
      end
      if (cmd_i.push) begin
        head_q   <= (head_q == HW'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
        fill_q   <= fill_q + 1'b1;
        sum_re_q <= sum_re_q + SUM_W'(re_q);
        sum_im_q <= sum_im_q + SUM_W'(im_q);
      end
      if (cmd_i.chunk) begin
        armed_q      <= 1'b0;
        pc_q         <= '0;
        prev_valid_q <= 1'b0;
        cnt_q        <= cnt_q + 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sig_q <= inv_q ? in_reference_i : in_signal_i;
      ref_q <= inv_q ? in_signal_i : in_reference_i;
      end_q <= in_end_i;
    end
    if (cmd_i.decide && ref_edge) begin
      n_q <= restart ? '0 : PI_W'(pc_q);
      p_q <= restart ? PC_W'(1) : pc_q + 1'b1;
      j_q <= '0;
    end
    if (cmd_i.latch_phase) begin
      phase_q <= pquot[PHASE_BITS-1:0];
      samp_q  <= (j_q == n_q) ? sig_q : prd_q;
    end
    if (cmd_i.tab) begin
      tab_q  <= CS_TAB[tidx];
      lo_q   <= tlo;
      quad_q <= phase_q[PHASE_BITS-1:PHASE_BITS-2];
    end
    if (cmd_i.cs) begin
      case (quad_q)
        2'd0: begin
          cos_q <= c0s;
          sin_q <= s0s;
        end
        2'd1: begin
          cos_q <= -s0s;
          sin_q <= c0s;
        end
        2'd2: begin
          cos_q <= -c0s;
          sin_q <= -s0s;
        end
        default: begin
          cos_q <= s0s;
          sin_q <= -c0s;
        end
      endcase
    end
    if (cmd_i.mul) begin
      re_q <= PW'(pre);
      im_q <= PW'(pim);
    end
    if (cmd_i.push) begin
      j_q <= j_q + 1'b1;
    end
    if (cmd_i.mean_im) begin
      mr_q <= mquot[MW-1:0];
    end
    if (cmd_i.mean_fin) begin
      mi_q <= mquot[MW-1:0];
    end
    if (cmd_i.sq1) begin
      sq_q <= mr_q * mr_q;
    end
    if (cmd_i.sq2) begin
      acc_q <= sq_q;
      sq_q  <= mi_q * mi_q;
    end
    if (cmd_i.emit) begin
      mag_q  <= (mag_full > clid_pkg::MAG_MAX) ? clid_pkg::MAG_MAX[clid_pkg::MAG_W-1:0]
                                               : mag_full[clid_pkg::MAG_W-1:0];
      cidx_q <= cnt_q;
    end
  end

  // period buffer
  always_ff @(posedge clk_i) begin
    if (pwe) begin
      pmem[pc_q[PI_W-1:0]] <= sig_q;
    end
    if (cmd_i.issue) begin
      prd_q <= pmem[j_q];
    end
  end

  // window buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      wmem[head_q] <= {im_q, re_q};
    end
    if (cmd_i.rd_oldest) begin
      wrd_q <= wmem[old_idx];
    end
  end

  assign stat_o.ref_edge    = ref_edge;
  assign stat_o.div_done    = pdiv_done;
  assign stat_o.last        = (j_q == n_q);
  assign stat_o.fill_ge_len = fill_q >= eff_len;
  assign stat_o.fill_gt_len = fill_q > eff_len;
  assign stat_o.fill_eq_len = fill_q == eff_len;
  assign stat_o.end_flag    = end_q;
  assign stat_o.mean_done   = mdiv_done;
  assign stat_o.sqrt_done   = sqrt_done;
  assign stat_o.out_busy    = out_valid_q;

  assign out_valid_o       = out_valid_q;
  assign out_magnitude_o   = mag_q;
  assign out_chunk_index_o = cidx_q;

endmodule

`default_nettype wire

>>> rtl/core/clid_ctrl.sv
// ----------------------------------------------------------------------------
// Lock-in controller
// Sequences decide, period flush, window update and chunk-end result.
// ----------------------------------------------------------------------------
`default_nettype none

module clid_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire clid_pkg::clid_stat_t stat_i,
  output clid_pkg::clid_cmd_t       cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECIDE, S_PREP, S_DIV, S_TAB, S_CS, S_MUL, S_CHK, S_DROP,
    S_TAIL, S_ECHK, S_EDROP, S_MRE, S_MIM, S_SQ1, S_SQ2, S_SQS, S_SQRT, S_EMIT
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   ready_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && ready_q) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = stat_i.ref_edge ? S_PREP : S_TAIL;
      end
      S_PREP: begin
        cmd_o.issue = 1'b1;
        state_d     = S_DIV;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.latch_phase = 1'b1;
          state_d           = S_TAB;
        end
      end
      S_TAB: begin
        cmd_o.tab = 1'b1;
        state_d   = S_CS;
      end
      S_CS: begin
        cmd_o.cs = 1'b1;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CHK;
      end
      S_CHK: begin
        if (stat_i.fill_ge_len) begin
          cmd_o.rd_oldest = 1'b1;
          state_d         = S_DROP;
        end else begin
          cmd_o.push = 1'b1;
          state_d    = stat_i.last ? S_TAIL : S_PREP;
        end
      end
      S_DROP: begin
        cmd_o.drop = 1'b1;
        state_d    = S_CHK;
      end
      S_TAIL: begin
        if (stat_i.end_flag) begin
          cmd_o.chunk = 1'b1;
          state_d     = S_ECHK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_ECHK: begin
        if (stat_i.fill_gt_len) begin
          cmd_o.rd_oldest = 1'b1;
          state_d         = S_EDROP;
        end else if (stat_i.fill_eq_len) begin
          cmd_o.mean_re = 1'b1;
          state_d       = S_MRE;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EDROP: begin
        cmd_o.drop = 1'b1;
        state_d    = S_ECHK;
      end
      S_MRE: begin
        if (stat_i.mean_done) begin
          cmd_o.mean_im = 1'b1;
          state_d       = S_MIM;
        end
      end
      S_MIM: begin
        if (stat_i.mean_done) begin
          cmd_o.mean_fin = 1'b1;
          state_d        = S_SQ1;
        end
      end
      S_SQ1: begin
        cmd_o.sq1 = 1'b1;
        state_d   = S_SQ2;
      end
      S_SQ2: begin
        cmd_o.sq2 = 1'b1;
        state_d   = S_SQS;
      end
      S_SQS: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = S_SQRT;
      end
      S_SQRT: begin
        if (stat_i.sqrt_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = ready_q;

endmodule

`default_nettype wire

>>> rtl/core/chopper_lock_in_demodulator_unit.sv
// ----------------------------------------------------------------------------
// Chopper lock-in demodulator
// Demodulates a signal channel against a chopper reference per reference
// period and reports the magnitude of the mean over a sliding window at chunk ends.
//
//   channel  dir  handshake                 content
//   s_axis   in   s_axis_tvalid/tready      signal, reference; tlast = chunk end
//   m_axis   out  m_axis_tvalid/tready      magnitude, chunk index
//   cfg      in   cfg_valid_i/cfg_ready_o   index 0 window_len, 1 invert_lr
//
// An edge flushes the buffered period through the bit-serial phase divider,
// one pushed product at a time, and drops the oldest product from the window
// while it is full. A chunk end with a full window adds two mean divisions
// and a square root. Both buffers start undefined; reset needs no clearing
// pass. A pending result holds the controller, and with it the input, only
// once the next result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module chopper_lock_in_demodulator_unit #(
  parameter int unsigned WINDOW_DEPTH = clid_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned MAX_PERIOD   = clid_pkg::MAX_PERIOD_DEF,
  parameter int unsigned PHASE_BITS   = clid_pkg::PHASE_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [31:0]                        s_axis_tdata,  // signal_sample, reference_sample
  input  wire logic                               s_axis_tlast,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [31:0]                             m_axis_tdata,  // magnitude, chunk_index
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [clid_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [clid_pkg::WLEN_W-1:0]        cfg_data_i
);

  clid_pkg::clid_cmd_t  cmd;
  clid_pkg::clid_stat_t stat;
  logic [clid_pkg::MAG_W-1:0]  magnitude;
  logic [clid_pkg::CIDX_W-1:0] chunk_index;

  assign cfg_ready_o = 1'b1;

  clid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  clid_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MAX_PERIOD   (MAX_PERIOD),
    .PHASE_BITS   (PHASE_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_signal_i       (signed'(s_axis_tdata[15:0])),
    .in_reference_i    (signed'(s_axis_tdata[31:16])),
    .in_end_i          (s_axis_tlast),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_magnitude_o   (magnitude),
    .out_chunk_index_o (chunk_index)
  );

  assign m_axis_tdata = {chunk_index, magnitude};

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a word is in work");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !m_axis_tvalid)
    else $error("result written over a pending result");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !stat.fill_ge_len)
    else $error("product pushed into a full window");

  a_read_then_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_oldest |=> cmd.drop)
    else $error("oldest product read without drop");

endmodule

`default_nettype wire
